FILE: rtl/core/subsum_pkg.sv
// ----------------------------------------------------------------------------
// subsum_pkg
// Shared types and constants for the submatrix target-sum counter.
// ----------------------------------------------------------------------------
package subsum_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int VAL_W     = 16;
	localparam int TGT_W     = 32;
	localparam int CNT_W     = 23;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
	localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(64);
	localparam logic [CFG_W-1:0] COL_COUNT_RST = CFG_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 1'b0,
		REG_COL_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

endpackage

FILE: rtl/core/submatrix_target_sum_counter_top.sv
// ----------------------------------------------------------------------------
// submatrix_target_sum_counter_top
// Loads a grid of signed cells in row-major order and, on a query, counts
// the subrectangles whose cell sum equals the target.
//
//   channel  direction  handshake             payload
//   item     in         item_valid/item_stall opcode, cell_value, target_sum
//   result   out        result_valid/stall    match_count
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Load items are accepted back to back while idle; item_stall holds new items
// while a query runs. A query is worked by the single shared adder that
// first builds column strip sums for each row pair, then walks every
// column pair over those sums, one add and compare per cycle.
// Reset initialises the registers only; the cell memory holds no reset value.
// A finished count waits in the output register while loads go on; a new
// query waits for the output register to drain before it finishes.
// ----------------------------------------------------------------------------
module submatrix_target_sum_counter_top
	import subsum_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    opcode,
	input  logic signed [VAL_W-1:0] cell_value,
	input  logic signed [TGT_W-1:0] target_sum,

	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [CNT_W-1:0]        match_count,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
	localparam int LP_W     = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
	localparam int RN_W     = $clog2(MAX_ROWS + 1);
	localparam int CN_W     = $clog2(MAX_COLS + 1);
	localparam int RI_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CI_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int PW       = (LP_W + 1 > RN_W + CN_W) ? LP_W + 1 : RN_W + CN_W;
	localparam int COL_W    = VAL_W + $clog2(MAX_ROWS);
	localparam int RUN_W    = COL_W + $clog2(MAX_COLS);
	localparam int CMP_W    = (RUN_W > TGT_W) ? RUN_W : TGT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_ACC_END,
		S_SCAN,
		S_FIN,
		S_DONE
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] col_count_q;
	logic [LP_W-1:0]  load_pos_q;

	logic signed [TGT_W-1:0] target_q;
	logic [RI_W-1:0]         r1_q, r2_q;
	logic [CI_W-1:0]         c1_q, c2_q;
	logic [LP_W-1:0]         r1_base_q, r2_base_q;
	logic signed [RUN_W-1:0] run_q;
	logic [CNT_W-1:0]        count_q;
	logic                    result_valid_q;
	logic [CNT_W-1:0]        match_count_q;

	// Stage after the memory reads.
	logic                    acc_vld_s1, scan_vld_s1, first_s1;
	logic [CI_W-1:0]         col_idx_s1;
	logic signed [VAL_W-1:0] cell_rd_s1;
	logic signed [COL_W-1:0] col_rd_s1;

	logic signed [VAL_W-1:0] cell_mem [CELL_CAP];
	logic signed [COL_W-1:0] col_mem  [MAX_COLS];

	logic [RN_W-1:0]         rows_eff;
	logic [CN_W-1:0]         cols_eff;
	logic [RI_W-1:0]         rows_last;
	logic [CI_W-1:0]         cols_last;
	logic [LP_W-1:0]         cols_step;
	logic [PW-1:0]           grid_total;
	logic [PW-1:0]           pos_inc;
	logic                    item_acc;
	logic                    load_we;
	logic                    cfg_we;
	logic [LP_W-1:0]         cell_rd_addr;
	logic [CI_W-1:0]         col_rd_addr;
	logic signed [RUN_W-1:0] cell_ext, col_ext, op_a, op_b, sum;
	logic                    hit;

	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign load_we      = item_acc && (op_t'(opcode) == OP_LOAD) && !cfg_we;
	assign result_valid = result_valid_q;
	assign match_count  = match_count_q;

	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = RN_W'(1);
		end else if (row_count_q > MAX_ROWS) begin
			rows_eff = RN_W'(MAX_ROWS);
		end else begin
			rows_eff = RN_W'(row_count_q);
		end
		if (col_count_q == '0) begin
			cols_eff = CN_W'(1);
		end else if (col_count_q > MAX_COLS) begin
			cols_eff = CN_W'(MAX_COLS);
		end else begin
			cols_eff = CN_W'(col_count_q);
		end
	end

	assign rows_last  = RI_W'(rows_eff - RN_W'(1));
	assign cols_last  = CI_W'(cols_eff - CN_W'(1));
	assign cols_step  = LP_W'(cols_eff);
	assign grid_total = PW'(rows_eff) * PW'(cols_eff);
	assign pos_inc    = PW'(load_pos_q) + PW'(1);

	assign cell_rd_addr = r2_base_q + LP_W'(c2_q);
	assign col_rd_addr  = c2_q;

	// The one adder serves both phases: strip build adds a cell to its
	// column sum, the scan adds a column sum to the running width sum.
	assign cell_ext = RUN_W'(cell_rd_s1);
	assign col_ext  = RUN_W'(col_rd_s1);
	always_comb begin
		if (acc_vld_s1) begin
			op_a = first_s1 ? '0 : col_ext;
			op_b = cell_ext;
		end else begin
			op_a = first_s1 ? '0 : run_q;
			op_b = col_ext;
		end
	end
	assign sum = op_a + op_b;
	assign hit = scan_vld_s1 && (CMP_W'(sum) == CMP_W'(target_q));

	always_ff @(posedge clk) begin
		if (load_we) begin
			cell_mem[load_pos_q] <= cell_value;
		end
		cell_rd_s1 <= cell_mem[cell_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_vld_s1) begin
			col_mem[col_idx_s1] <= COL_W'(sum);
		end
		col_rd_s1 <= col_mem[col_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			row_count_q    <= ROW_COUNT_RST;
			col_count_q    <= COL_COUNT_RST;
			load_pos_q     <= '0;
			target_q       <= '0;
			r1_q           <= '0;
			r2_q           <= '0;
			c1_q           <= '0;
			c2_q           <= '0;
			r1_base_q      <= '0;
			r2_base_q      <= '0;
			run_q          <= '0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
			match_count_q  <= '0;
			acc_vld_s1     <= 1'b0;
			scan_vld_s1    <= 1'b0;
			first_s1       <= 1'b0;
			col_idx_s1     <= '0;
		end else begin
			acc_vld_s1  <= (state_q == S_ACC);
			scan_vld_s1 <= (state_q == S_SCAN);
			first_s1    <= (state_q == S_ACC) ? (r2_q == r1_q) : (c2_q == c1_q);
			col_idx_s1  <= c2_q;

			if (scan_vld_s1) begin
				run_q <= sum;
			end
			if (hit && count_q != CNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end

			// In the finishing state the output register is handled below.
			if (result_valid_q && !result_stall && state_q != S_DONE) begin
				result_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROW_COUNT: row_count_q <= cfg_data;
					REG_COL_COUNT: col_count_q <= cfg_data;
					default: ;
				endcase
				load_pos_q <= '0;
			end else if (load_we) begin
				load_pos_q <= (pos_inc >= grid_total) ? '0 : LP_W'(pos_inc);
			end

			case (state_q)
				S_IDLE: begin
					if (item_acc && op_t'(opcode) == OP_QUERY) begin
						target_q  <= target_sum;
						r1_q      <= '0;
						r2_q      <= '0;
						c1_q      <= '0;
						c2_q      <= '0;
						r1_base_q <= '0;
						r2_base_q <= '0;
						count_q   <= '0;
						state_q   <= S_ACC;
					end
				end
				S_ACC: begin
					if (c2_q == cols_last) begin
						state_q <= S_ACC_END;
					end else begin
						c2_q <= c2_q + CI_W'(1);
					end
				end
				S_ACC_END: begin
					// The last column sum is written this cycle.
					c1_q    <= '0;
					c2_q    <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (c2_q == cols_last) begin
						if (c1_q == cols_last) begin
							c2_q <= '0;
							if (r2_q == rows_last) begin
								if (r1_q == rows_last) begin
									state_q <= S_FIN;
								end else begin
									r1_q      <= r1_q + RI_W'(1);
									r2_q      <= r1_q + RI_W'(1);
									r1_base_q <= r1_base_q + cols_step;
									r2_base_q <= r1_base_q + cols_step;
									state_q   <= S_ACC;
								end
							end else begin
								r2_q      <= r2_q + RI_W'(1);
								r2_base_q <= r2_base_q + cols_step;
								state_q   <= S_ACC;
							end
						end else begin
							c1_q <= c1_q + CI_W'(1);
							c2_q <= c1_q + CI_W'(1);
						end
					end else begin
						c2_q <= c2_q + CI_W'(1);
					end
				end
				S_FIN: begin
					// The last compare lands in the count this cycle.
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						match_count_q  <= count_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the submatrix target-sum counter. Grids are loaded
// cell by cell and queried with targets. A local model keeps its own copy
// of the cells and the size registers and counts matching rectangles by
// brute force. Every returned count is checked in order against it; most
// runs add random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb
	import subsum_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL_CAP = DEF_MAX_ROWS * DEF_MAX_COLS;

	typedef struct {
		logic [TGT_W-1:0] target;
		logic [CNT_W-1:0] count;
	} query_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    item_valid   = 1'b0;
	logic                    item_stall;
	logic                    opcode       = 1'b0;
	logic signed [VAL_W-1:0] cell_value   = '0;
	logic signed [TGT_W-1:0] target_sum   = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [CNT_W-1:0]        match_count;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index    = '0;
	logic [CFG_W-1:0]        cfg_data     = '0;

	// Local copy of the block state.
	logic signed [VAL_W-1:0] grid_mem [CELL_CAP];
	logic [CFG_W-1:0]        rows_reg   = ROW_COUNT_RST;
	logic [CFG_W-1:0]        cols_reg   = COL_COUNT_RST;
	int unsigned             fill_pos   = 0;
	int unsigned             filled_len = 0;

	query_t open_queries[$];
	int     err_count = 0;
	int     send_idle = 0;
	int     recv_idle = 0;

	submatrix_target_sum_counter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.cell_value   (cell_value),
		.target_sum   (target_sum),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.match_count  (match_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle);
	end

	function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return v;
	endfunction

	function automatic longint rect_sum(int unsigned r1, int unsigned r2,
			int unsigned c1, int unsigned c2);
		int unsigned nc;
		longint acc;
		nc = clamp_dim(cols_reg, DEF_MAX_COLS);
		acc = 0;
		for (int unsigned r = r1; r <= r2; r++)
			for (int unsigned c = c1; c <= c2; c++)
				acc += grid_mem[r * nc + c];
		return acc;
	endfunction

	function automatic logic [CNT_W-1:0] count_target_rects(logic signed [TGT_W-1:0] target);
		int unsigned nr, nc, hits;
		longint goal;
		nr = clamp_dim(rows_reg, DEF_MAX_ROWS);
		nc = clamp_dim(cols_reg, DEF_MAX_COLS);
		goal = target;
		hits = 0;
		for (int unsigned r1 = 0; r1 < nr; r1++)
			for (int unsigned r2 = r1; r2 < nr; r2++)
				for (int unsigned c1 = 0; c1 < nc; c1++)
					for (int unsigned c2 = c1; c2 < nc; c2++)
						if (rect_sum(r1, r2, c1, c2) == goal && hits < CNT_MAX)
							hits++;
		return hits[CNT_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] rand_cell();
		case ($urandom_range(9))
			6: return 16'h8000;
			7: return 16'h7fff;
			8, 9: return VAL_W'($urandom);
			default: return VAL_W'($urandom_range(6)) - VAL_W'(3);
		endcase
	endfunction

	// Half the time the sum of a real rectangle, so that matches are common.
	function automatic logic [TGT_W-1:0] pick_target();
		int unsigned nr, nc, r1, r2, c1, c2;
		nr = clamp_dim(rows_reg, DEF_MAX_ROWS);
		nc = clamp_dim(cols_reg, DEF_MAX_COLS);
		r1 = $urandom_range(nr - 1);
		r2 = $urandom_range(nr - 1, r1);
		c1 = $urandom_range(nc - 1);
		c2 = $urandom_range(nc - 1, c1);
		case ($urandom_range(9))
			5: return '0;
			6: return TGT_W'($urandom_range(6)) - TGT_W'(3);
			7: return 32'h8000_0000;
			8: return 32'h7fff_ffff;
			9: return $urandom;
			default: return TGT_W'(rect_sum(r1, r2, c1, c2));
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : result_check
		query_t exp_q;
		if (arst_n && result_valid && !result_stall) begin
			if (open_queries.size() == 0) begin
				report_mismatch($sformatf("count %0d with no query pending", match_count));
			end else begin
				exp_q = open_queries.pop_front();
				if (match_count !== exp_q.count)
					report_mismatch($sformatf("target %0d: count %0d, expected %0d",
						$signed(exp_q.target), match_count, exp_q.count));
			end
		end
	end

	task automatic set_idle(int s, int r);
		send_idle = s;
		recv_idle = r;
	endtask

	// Sends one item; the field that the opcode does not use gets noise.
	task automatic send_item(op_t op, logic [TGT_W-1:0] data);
		logic [VAL_W-1:0] val;
		logic [TGT_W-1:0] tgt;
		int unsigned cells;
		val = (op == OP_LOAD) ? data[VAL_W-1:0] : VAL_W'($urandom);
		tgt = (op == OP_QUERY) ? data : $urandom;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode     <= op;
		cell_value <= val;
		target_sum <= tgt;
		do @(posedge clk); while (item_stall);
		if (op == OP_LOAD) begin
			cells = clamp_dim(rows_reg, DEF_MAX_ROWS) * clamp_dim(cols_reg, DEF_MAX_COLS);
			grid_mem[fill_pos] = val;
			if (fill_pos + 1 > filled_len)
				filled_len = fill_pos + 1;
			fill_pos = (fill_pos + 1 >= cells) ? 0 : fill_pos + 1;
		end else begin
			open_queries.push_back('{tgt, count_target_rects(tgt)});
		end
	endtask

	// Loads give no result, so allow the last one to retire after the queue drains.
	task automatic settle();
		item_valid <= 1'b0;
		while (open_queries.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROW_COUNT)
			rows_reg = val;
		else
			cols_reg = val;
		fill_pos = 0;
	endtask

	task automatic test_single_cell();
		write_reg(REG_ROW_COUNT, 7'd1);
		write_reg(REG_COL_COUNT, 7'd1);
		send_item(OP_LOAD, 32'h0000_8000);
		send_item(OP_QUERY, 32'hffff_8000);
		send_item(OP_QUERY, 32'h0000_0000);
		// The grid is one cell, so this load wraps onto the same cell.
		send_item(OP_LOAD, 32'h0000_7fff);
		send_item(OP_QUERY, 32'h0000_7fff);
		send_item(OP_QUERY, 32'h8000_0000);
		send_item(OP_QUERY, 32'h7fff_ffff);
	endtask

	task automatic test_wide_and_tall();
		logic [VAL_W-1:0] val;
		write_reg(REG_ROW_COUNT, 7'd1);
		write_reg(REG_COL_COUNT, 7'd64);
		for (int i = 0; i < 64; i++) begin
			val = (i == 63) ? 16'h8000 : (i % 2 == 1) ? 16'h8001 : 16'h7fff;
			send_item(OP_LOAD, {16'h0, val});
		end
		send_item(OP_QUERY, 32'h0);
		send_item(OP_QUERY, TGT_W'(rect_sum(0, 0, 0, 63)));
		send_item(OP_QUERY, 32'h0000_7fff);
		// Out-of-range sizes clamp: 64 rows by 1 column over the same cells.
		write_reg(REG_ROW_COUNT, 7'd127);
		write_reg(REG_COL_COUNT, 7'd0);
		send_item(OP_QUERY, 32'h0);
		send_item(OP_QUERY, TGT_W'(rect_sum(0, 63, 0, 0)));
		write_reg(REG_ROW_COUNT, 7'd64);
		send_item(OP_QUERY, pick_target());
	endtask

	task automatic test_wrap_and_restart();
		write_reg(REG_ROW_COUNT, 7'd2);
		write_reg(REG_COL_COUNT, 7'd3);
		repeat (8) send_item(OP_LOAD, rand_cell());
		send_item(OP_QUERY, TGT_W'(rect_sum(0, 1, 0, 2)));
		// A register write sends loading back to the first cell.
		repeat (3) send_item(OP_LOAD, rand_cell());
		write_reg(REG_COL_COUNT, 7'd3);
		repeat (3) send_item(OP_LOAD, rand_cell());
		send_item(OP_QUERY, TGT_W'(rect_sum(0, 1, 0, 2)));
		send_item(OP_QUERY, pick_target());
	endtask

	task automatic test_random_grids();
		int n_items, n_queries, cells;
		logic [CFG_W-1:0] rows, cols;
		n_items = 0;
		n_queries = 0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: set_idle(38, 77);
				1: set_idle(77, 38);
				default: set_idle(0, 0);
			endcase
			while (n_items < 8 * (ph + 1) || n_queries < 2 * (ph + 1)) begin
				rows = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(1, 8))
					: CFG_W'($urandom_range(1, 5));
				cols = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(1, 8))
					: CFG_W'($urandom_range(1, 5));
				if ($urandom_range(15) == 0)
					rows = '0;
				if ($urandom_range(1) == 0) begin
					write_reg(REG_ROW_COUNT, rows);
					write_reg(REG_COL_COUNT, cols);
				end else begin
					write_reg(REG_COL_COUNT, cols);
					write_reg(REG_ROW_COUNT, rows);
				end
				cells = clamp_dim(rows, DEF_MAX_ROWS) * clamp_dim(cols, DEF_MAX_COLS);
				// Sometimes query the stale cells left over from the last grid.
				if (filled_len < cells || $urandom_range(3) != 0) begin
					repeat (cells + (($urandom_range(4) == 0) ? $urandom_range(1, cells) : 0)) begin
						send_item(OP_LOAD, rand_cell());
						n_items++;
					end
				end
				repeat ($urandom_range(2, 5)) begin
					if ($urandom_range(3) == 0) begin
						repeat ($urandom_range(1, cells)) begin
							send_item(OP_LOAD, rand_cell());
							n_items++;
						end
					end
					send_item(OP_QUERY, pick_target());
					n_items++;
					n_queries++;
				end
			end
		end
	endtask

	initial begin
		set_idle(38, 77);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_cell();
		test_wide_and_tall();
		test_wrap_and_restart();
		test_random_grids();
		settle();
		repeat (16) @(posedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
